// File: rtl/edmt_pkg.sv
// Shared field widths for the egg-drop minimum-trials block.
package edmt_pkg;

    localparam int CAP_W   = 5;   // capsules field
    localparam int BKR_W   = 8;   // beakers field
    localparam int TRI_W   = 8;   // min_trials field
    localparam int S_DATA_W = 16; // capsules + beakers, padded to bytes
    localparam int M_DATA_W = 8;

endpackage

// File: rtl/edmt_ram.sv
// Simple dual-port row memory: one write port, one registered read port.
module edmt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/egg_drop_min_trials_top.sv
// Egg-drop minimum trials: DP over two ping-pong rows with one shared max/min unit.
//
//  channel | dir | beat contents (lsb first)           | handshake
//  s_axis  | in  | capsules[4:0], beakers[12:5], pad   | i_s_tvalid / o_s_tready
//  m_axis  | out | min_trials[7:0]                     | o_m_tvalid / i_m_tready
//
// One split point per cycle while a cell runs: rows 2..k, cell j reads split points
// 1..j and then writes its result; one capsule or zero beakers skip the DP and go
// straight to the result. The row memory read port sets the one-step-per-cycle pace.
// Synchronous active-low reset clears control only; row memories are not cleared.
// Input is not ready while an item is in work; a stalled result sits in the output
// register while the next beat is taken, and the sequencer waits on it at the end.
module egg_drop_min_trials_top #(
    parameter int MAX_CAPSULES = 16,
    parameter int MAX_BEAKERS  = 255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [edmt_pkg::S_DATA_W-1:0] i_s_tdata,  // capsules[4:0], beakers[12:5]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [edmt_pkg::M_DATA_W-1:0] o_m_tdata   // min_trials[7:0]
);
    import edmt_pkg::*;

    localparam int IW = $clog2(MAX_BEAKERS + 1);
    localparam int EW = $clog2(MAX_CAPSULES + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH, S_RESULT} t_state;

    t_state          r_state;
    logic [EW-1:0]   r_eggs;
    logic [EW-1:0]   r_i;
    logic [IW-1:0]   r_floors;
    logic [IW-1:0]   r_j;
    logic [IW-1:0]   r_l;
    logic [IW-1:0]   r_best;
    logic [IW-1:0]   r_res;
    logic            r_bank;
    logic            r_vld;
    logic [IW-1:0]   r_pl;
    logic            r_pzero;
    logic            r_pfirst;
    logic            r_ovld;
    logic [TRI_W-1:0] r_out;

    logic [CAP_W-1:0] in_caps;
    logic [BKR_W-1:0] in_bkrs;
    logic [EW-1:0]    eggs_c;
    logic [IW-1:0]    floors_c;
    logic             s_acc;
    logic             first_row;
    logic [IW-1:0]    prev_addr, cur_addr;
    logic [IW-1:0]    a_q, b_q, prev_q, cur_q;
    logic [IW-1:0]    below, above, worst, cand;
    logic             we_a, we_b;

    assign in_caps = i_s_tdata[CAP_W-1:0];
    assign in_bkrs = i_s_tdata[CAP_W +: BKR_W];

    always_comb begin
        if (in_caps == '0) begin
            eggs_c = EW'(1);
        end else if (32'(in_caps) > MAX_CAPSULES) begin
            eggs_c = EW'(MAX_CAPSULES);
        end else begin
            eggs_c = EW'(in_caps);
        end
        if (32'(in_bkrs) > MAX_BEAKERS) begin
            floors_c = IW'(MAX_BEAKERS);
        end else begin
            floors_c = IW'(in_bkrs);
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign first_row  = ({1'b0, r_i} == (EW + 1)'(2));

    // issue addresses for split point l
    assign prev_addr = r_l - IW'(1);
    assign cur_addr  = r_j - r_l;

    // r_bank high: ram a holds the current row
    assign prev_q = r_bank ? b_q : a_q;
    assign cur_q  = r_bank ? a_q : b_q;
    assign we_a   = (r_state == S_FLUSH) && r_bank;
    assign we_b   = (r_state == S_FLUSH) && !r_bank;

    edmt_ram #(.DEPTH(MAX_BEAKERS + 1), .WIDTH(IW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_j),
        .i_wdata (cand),
        .i_raddr (r_bank ? cur_addr : prev_addr),
        .o_rdata (a_q)
    );

    edmt_ram #(.DEPTH(MAX_BEAKERS + 1), .WIDTH(IW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_j),
        .i_wdata (cand),
        .i_raddr (r_bank ? prev_addr : cur_addr),
        .o_rdata (b_q)
    );

    // shared unit: 1 + max(below, above), folded into the running minimum
    always_comb begin
        // row 1 is the identity, and column 0 of any row is 0 (never stored)
        below = (r_pfirst || (r_pl == IW'(1))) ? (r_pl - IW'(1)) : prev_q;
        above = r_pzero ? '0 : cur_q;                 // current row at 0 is 0
        worst = ((below > above) ? below : above) + IW'(1);
        cand  = (worst < r_best) ? worst : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_vld    <= (r_state == S_RUN);
            r_pl     <= r_l;
            r_pzero  <= (r_l == r_j);
            r_pfirst <= first_row;
            if ((r_state != S_RESULT) && r_ovld && i_m_tready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_eggs   <= eggs_c;
                        r_floors <= floors_c;
                        if ((eggs_c == EW'(1)) || (floors_c == '0)) begin
                            r_res   <= floors_c;
                            r_state <= S_RESULT;
                        end else begin
                            r_i     <= EW'(2);
                            r_j     <= IW'(1);
                            r_l     <= IW'(1);
                            r_best  <= IW'(1);
                            r_bank  <= 1'b0;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (r_vld) begin
                        r_best <= cand;
                    end
                    if (r_l == r_j) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_l <= r_l + IW'(1);
                    end
                end
                S_FLUSH: begin
                    // cand is written to the current row this cycle
                    r_l <= IW'(1);
                    if (r_j == r_floors) begin
                        if (r_i == r_eggs) begin
                            r_res   <= cand;
                            r_state <= S_RESULT;
                        end else begin
                            r_i     <= r_i + EW'(1);
                            r_j     <= IW'(1);
                            r_best  <= IW'(1);
                            r_bank  <= ~r_bank;
                            r_state <= S_RUN;
                        end
                    end else begin
                        r_j     <= r_j + IW'(1);
                        r_best  <= r_j + IW'(1);
                        r_state <= S_RUN;
                    end
                end
                S_RESULT: begin
                    if (!r_ovld || i_m_tready) begin
                        r_out   <= TRI_W'(r_res);
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_out;

endmodule

// File: rtl/edmt_chk.sv
// Port-level checker for the egg-drop block, bound to the top level.
module edmt_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [edmt_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [edmt_pkg::M_DATA_W-1:0] o_m_tdata
);
    import edmt_pkg::*;

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result beat valid right after reset");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("input ready while an item is in work");

    a_zero_bkr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_s_tdata[CAP_W +: BKR_W] == '0) && !o_m_tvalid)
        |=> ##1 (o_m_tvalid && (o_m_tdata[TRI_W-1:0] == '0)))
        else $error("zero beakers did not give a zero result beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind egg_drop_min_trials_top edmt_chk u_edmt_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
